// File: hdl/ccps_pkg.sv
// ----------------------------------------------------------------------------
// ccps_pkg
// shared types and constants of the cell charge particle splitter
// ----------------------------------------------------------------------------
`default_nettype none

package ccps_pkg;

    localparam int CELL_W      = 16;
    localparam int SPEC_W      = 4;
    localparam int Q_W         = 32;
    localparam int POS_W       = 17;
    localparam int LVL_W       = 3;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;
    localparam int MAX_LEVEL_DEF = 5;

    // x0 has 17 quotient bits, one per divider step
    localparam int DIV_STEPS   = 17;
    localparam int DIV_CNT_W   = 5;

    localparam logic [Q_W-1:0]   TARGET_RESET = 32'h0001_0000;
    localparam logic [POS_W-1:0] POS_ONE      = 17'h1_0000;

    // register select bit of paddr
    localparam logic REG_TARGET  = 1'b0;
    localparam logic REG_SPECIES = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SOLVE,
        ST_EMIT
    } ccps_state_t;

    typedef struct packed {
        logic [Q_W-1:0]    target_weight;
        logic [SPEC_W-1:0] species_tag;
    } ccps_cfg_t;

    typedef struct packed {
        logic             busy;
        logic [POS_W-1:0] quotient;
    } ccps_div_status_t;

    typedef struct packed {
        logic             busy;
        logic [LVL_W-1:0] level;
    } ccps_lvl_status_t;

endpackage

`default_nettype wire

// File: hdl/cell_charge_particle_splitter_top.sv
// ----------------------------------------------------------------------------
// cell_charge_particle_splitter_top: splits mesh cells into weighted particles
// each cell is solved by the divider and both level units, then emitted piece by piece
// (N = 2^k_high + 2^k_low pieces), held by output stalls; the next cell is taken only
// after the last piece; a zero-charge cell is dropped; reset: rst_n clears control at once
// ----------------------------------------------------------------------------
`default_nettype none

module cell_charge_particle_splitter_top
#(
    parameter int MAX_LEVEL = ccps_pkg::MAX_LEVEL_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // apb configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ccps_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ccps_pkg::DATA_W-1:0] pwdata,
    output logic      [ccps_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    // cell input
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [79:0]                 s_tdata,  // cell_index, charge_low_side, charge_high_side
    // particle output
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [71:0]                 m_tdata,  // out_cell, position, weight, zero fill
    output logic      [3:0]                  m_tuser,  // out_species
    output logic                             m_tlast   // last
);

    localparam int CNT_W = MAX_LEVEL;
    localparam int ACC_W = ccps_pkg::POS_W + MAX_LEVEL + 1;

    ccps_pkg::ccps_cfg_t        cfg;
    ccps_pkg::ccps_div_status_t div_st;
    ccps_pkg::ccps_lvl_status_t lvl_lo_st, lvl_hi_st;
    ccps_pkg::ccps_state_t      state_reg, state_next;

    logic [ccps_pkg::CELL_W-1:0] in_cell;
    logic [ccps_pkg::Q_W-1:0]    in_qlo, in_qhi;
    logic [ccps_pkg::Q_W:0]      in_sum;
    logic                        accept, start, solve_done, emit_fire, last_piece;

    logic [ccps_pkg::CELL_W-1:0] cell_reg;
    logic [ccps_pkg::Q_W-1:0]    qlo_reg, qhi_reg;
    logic [ccps_pkg::POS_W-1:0]  x0_reg;
    logic                        region_reg;
    logic [CNT_W-1:0]            piece_reg;
    logic [ACC_W-1:0]            acc_reg;

    logic                        out_valid_reg;
    logic [ccps_pkg::CELL_W-1:0] out_cell_reg;
    logic [ccps_pkg::SPEC_W-1:0] out_spec_reg;
    logic [ccps_pkg::POS_W-1:0]  out_pos_reg;
    logic [ccps_pkg::Q_W-1:0]    out_w_reg;
    logic                        out_last_reg;

    logic [ccps_pkg::LVL_W-1:0]  cur_lvl;
    logic [ccps_pkg::POS_W-1:0]  cur_len, cur_start;
    logic [ccps_pkg::Q_W-1:0]    cur_q;
    logic [CNT_W-1:0]            piece_mask;
    logic [ACC_W-1:0]            acc_shift;
    logic [ACC_W-1:0]            pos_sum;

    assign in_cell = s_tdata[15:0];
    assign in_qlo  = s_tdata[47:16];
    assign in_qhi  = s_tdata[79:48];
    assign in_sum  = {1'b0, in_qlo} + {1'b0, in_qhi};

    ccps_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ccps_div_unit u_div
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .charge_high (in_qhi),
        .divisor     (in_sum),
        .status      (div_st)
    );

    ccps_level_unit #(.MAX_LEVEL(MAX_LEVEL)) u_lvl_lo
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .charge        (in_qlo),
        .target_weight (cfg.target_weight),
        .status        (lvl_lo_st)
    );

    ccps_level_unit #(.MAX_LEVEL(MAX_LEVEL)) u_lvl_hi
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .charge        (in_qhi),
        .target_weight (cfg.target_weight),
        .status        (lvl_hi_st)
    );

    // current region: high region is emitted first
    assign cur_lvl    = region_reg ? lvl_hi_st.level : lvl_lo_st.level;
    assign cur_start  = region_reg ? x0_reg : '0;
    assign cur_len    = region_reg ? (ccps_pkg::POS_ONE - x0_reg) : x0_reg;
    assign cur_q      = region_reg ? qhi_reg : qlo_reg;
    assign piece_mask = CNT_W'((32'd1 << cur_lvl) - 32'd1);
    assign last_piece = (piece_reg == piece_mask);
    // acc holds (2m+1) * len
    assign acc_shift  = acc_reg >> (cur_lvl + 1'b1);
    assign pos_sum    = ACC_W'(cur_start) + acc_shift;

    assign accept     = s_tvalid && s_tready;
    assign emit_fire  = (state_reg == ccps_pkg::ST_EMIT) && (!out_valid_reg || m_tready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ccps_pkg::ST_IDLE:
                if (s_tvalid && (in_sum != '0))
                    state_next = ccps_pkg::ST_SOLVE;
            ccps_pkg::ST_SOLVE:
                if (!div_st.busy && !lvl_lo_st.busy && !lvl_hi_st.busy)
                    state_next = ccps_pkg::ST_EMIT;
            ccps_pkg::ST_EMIT:
                if (emit_fire && last_piece && !region_reg)
                    state_next = ccps_pkg::ST_IDLE;
            default:
                state_next = ccps_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready   = 1'b0;
        solve_done = 1'b0;
        unique case (state_reg)
            ccps_pkg::ST_IDLE:
                s_tready = 1'b1;
            ccps_pkg::ST_SOLVE:
                solve_done = !div_st.busy && !lvl_lo_st.busy && !lvl_hi_st.busy;
            ccps_pkg::ST_EMIT:
                s_tready = 1'b0;
            default:
                s_tready = 1'b0;
        endcase
    end

    // a cell with zero charge is taken and dropped
    assign start = accept && (in_sum != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ccps_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_reg <= 1'b0;
            piece_reg  <= '0;
        end
        else if (solve_done)
        begin
            region_reg <= 1'b1;
            piece_reg  <= '0;
        end
        else if (emit_fire)
        begin
            if (last_piece)
            begin
                region_reg <= 1'b0;
                piece_reg  <= '0;
            end
            else
                piece_reg <= piece_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cell_reg <= in_cell;
            qlo_reg  <= in_qlo;
            qhi_reg  <= in_qhi;
        end
        if (solve_done)
        begin
            x0_reg  <= div_st.quotient;
            acc_reg <= ACC_W'(ccps_pkg::POS_ONE - div_st.quotient);
        end
        else if (emit_fire)
        begin
            if (last_piece)
                acc_reg <= ACC_W'(x0_reg);
            else
                acc_reg <= acc_reg + ACC_W'({cur_len, 1'b0});
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_fire)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_cell_reg <= cell_reg;
            out_spec_reg <= cfg.species_tag;
            out_pos_reg  <= pos_sum[ccps_pkg::POS_W-1:0];
            out_w_reg    <= cur_q >> cur_lvl;
            out_last_reg <= last_piece && !region_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_w_reg, out_pos_reg, out_cell_reg};
    assign m_tuser  = out_spec_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// File: hdl/ccps_apb_regs.sv
// ----------------------------------------------------------------------------
// ccps_apb_regs
// configuration registers behind an apb-style slave port
// ----------------------------------------------------------------------------
`default_nettype none

module ccps_apb_regs
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ccps_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ccps_pkg::DATA_W-1:0] pwdata,
    output logic      [ccps_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output ccps_pkg::ccps_cfg_t              cfg
);

    logic [ccps_pkg::Q_W-1:0]    target_reg;
    logic [ccps_pkg::SPEC_W-1:0] species_reg;
    logic                        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg  <= ccps_pkg::TARGET_RESET;
            species_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                ccps_pkg::REG_TARGET:  target_reg  <= pwdata;
                ccps_pkg::REG_SPECIES: species_reg <= pwdata[ccps_pkg::SPEC_W-1:0];
                default:               target_reg  <= target_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            ccps_pkg::REG_TARGET:  prdata = target_reg;
            ccps_pkg::REG_SPECIES: prdata = {{(ccps_pkg::DATA_W-ccps_pkg::SPEC_W){1'b0}},
                                             species_reg};
            default:               prdata = '0;
        endcase
    end

    assign cfg.target_weight = target_reg;
    assign cfg.species_tag   = species_reg;

endmodule

`default_nettype wire

// File: hdl/ccps_div_unit.sv
// ----------------------------------------------------------------------------
// ccps_div_unit
// restoring divider, one quotient bit per cycle: x0 = (qhi << 16) / sum
// ----------------------------------------------------------------------------
`default_nettype none

module ccps_div_unit
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [ccps_pkg::Q_W-1:0]   charge_high,
    input  wire logic [ccps_pkg::Q_W:0]     divisor,
    output ccps_pkg::ccps_div_status_t      status
);

    logic                              busy_reg,   busy_next;
    logic [ccps_pkg::DIV_CNT_W-1:0]    cnt_reg,    cnt_next;
    logic [ccps_pkg::Q_W:0]            rem_reg,    rem_next;
    logic [ccps_pkg::Q_W:0]            div_reg,    div_next;
    logic [ccps_pkg::POS_W-1:0]        bits_reg,   bits_next;
    logic [ccps_pkg::POS_W-1:0]        quot_reg,   quot_next;
    logic [ccps_pkg::Q_W+1:0]          trial;
    logic                              fits;

    // shifted remainder with the next dividend bit brought down
    assign trial = {rem_reg, bits_reg[ccps_pkg::POS_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        bits_next = bits_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = ccps_pkg::DIV_CNT_W'(ccps_pkg::DIV_STEPS);
            // top 31 dividend bits above the quotient window, always below the sum
            rem_next  = {2'b00, charge_high[ccps_pkg::Q_W-1:1]};
            div_next  = divisor;
            bits_next = {charge_high[0], {(ccps_pkg::POS_W-1){1'b0}}};
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? (ccps_pkg::Q_W+1)'(trial - {1'b0, div_reg})
                             : trial[ccps_pkg::Q_W:0];
            bits_next = {bits_reg[ccps_pkg::POS_W-2:0], 1'b0};
            quot_next = {quot_reg[ccps_pkg::POS_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == ccps_pkg::DIV_CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        bits_reg <= bits_next;
        quot_reg <= quot_next;
    end

    assign status.busy     = busy_reg;
    assign status.quotient = quot_reg;

endmodule

`default_nettype wire

// File: hdl/ccps_level_unit.sv
// ----------------------------------------------------------------------------
// ccps_level_unit
// finds the halving level of one region, one compare per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ccps_level_unit
#(
    parameter int MAX_LEVEL = ccps_pkg::MAX_LEVEL_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [ccps_pkg::Q_W-1:0] charge,
    input  wire logic [ccps_pkg::Q_W-1:0] target_weight,
    output ccps_pkg::ccps_lvl_status_t    status
);

    localparam int SH_W = ccps_pkg::Q_W + MAX_LEVEL;

    logic                           busy_reg, busy_next;
    logic [ccps_pkg::LVL_W-1:0]     lvl_reg,  lvl_next;
    logic [ccps_pkg::Q_W-1:0]       q_reg,    q_next;
    logic [SH_W-1:0]                limit;
    logic                           over;

    assign limit = SH_W'(target_weight) << lvl_reg;
    assign over  = (lvl_reg < ccps_pkg::LVL_W'(MAX_LEVEL)) && (SH_W'(q_reg) > limit);

    always_comb
    begin
        busy_next = busy_reg;
        lvl_next  = lvl_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            lvl_next  = '0;
            q_next    = charge;
        end
        else if (busy_reg)
        begin
            if (over)
                lvl_next = lvl_reg + 1'b1;
            else
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            lvl_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            lvl_reg  <= lvl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign status.busy  = busy_reg;
    assign status.level = lvl_reg;

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell charge particle splitter testbench
// drives mesh cells over the input stream and checks every emitted particle
// against a local split predictor or, for typed rows, the particles listed in
// the row; a directed table comes first, then randomized cells under several
// target and species settings, with random idling on both streams but for one
// phase
module testbench;

    localparam int CELL_W  = ccps_pkg::CELL_W;
    localparam int SPEC_W  = ccps_pkg::SPEC_W;
    localparam int Q_W     = ccps_pkg::Q_W;
    localparam int POS_W   = ccps_pkg::POS_W;
    localparam int ADDR_W  = ccps_pkg::ADDR_W;
    localparam int DATA_W  = ccps_pkg::DATA_W;
    localparam logic [Q_W-1:0] TARGET_RESET = ccps_pkg::TARGET_RESET;

    localparam int MAX_LVL        = ccps_pkg::MAX_LEVEL_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF       = 40;
    localparam int PHASE_CELLS    = 70;
    localparam int NUM_PHASES     = 6;
    localparam int NUM_ROWS       = 18;

    localparam logic [ADDR_W-1:0] ADDR_TARGET  = {ccps_pkg::REG_TARGET, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_SPECIES = {ccps_pkg::REG_SPECIES, 2'b00};

    typedef struct {
        logic [CELL_W-1:0] cell_id;
        logic [SPEC_W-1:0] species;
        logic [POS_W-1:0]  pos;
        logic [Q_W-1:0]    weight;
        logic              last;
    } particle_t;

    // typed rows carry up to two particles read straight off the split rules
    typedef struct packed {
        logic [CELL_W-1:0] cell_id;
        logic [Q_W-1:0]    qlo;
        logic [Q_W-1:0]    qhi;
        logic              typed;
        logic [1:0]        n;
        logic [POS_W-1:0]  pos0;
        logic [Q_W-1:0]    w0;
        logic [POS_W-1:0]  pos1;
        logic [Q_W-1:0]    w1;
    } cell_row_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_tvalid;
    logic                s_tready;
    logic [79:0]         s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [71:0]         m_tdata;
    logic [3:0]          m_tuser;
    logic                m_tlast;

    logic [Q_W-1:0]      cfg_target;
    logic [SPEC_W-1:0]   cfg_species;
    particle_t           exp_particles [$];
    particle_t           exp_p;
    cell_row_t           dir_rows [NUM_ROWS];
    bit                  no_idle;
    int                  errors;
    int                  n_cells;
    int                  n_zero;
    int                  n_particles;
    int                  n_saturated;
    int                  n_settings;
    int                  idle_cycles;

    cell_charge_particle_splitter_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input string detail);
        begin
            errors++;
            if (errors <= 10)
            begin
                $display("mismatch: %s %s", what, detail);
            end
        end
    endtask

    task automatic push_particle(input logic [CELL_W-1:0] cell_id, input logic [POS_W-1:0] pos,
                                 input logic [Q_W-1:0] w, input logic last);
        particle_t p;
        begin
            p.cell_id = cell_id;
            p.species = cfg_species;
            p.pos     = pos;
            p.weight  = w;
            p.last    = last;
            exp_particles.push_back(p);
        end
    endtask

    // smallest level whose halved charge fits the target, saturating
    function automatic int split_level(input logic [63:0] q, input logic [Q_W-1:0] t);
        int k;
        begin
            k = 0;
            while (k < MAX_LVL && q > ({32'd0, t} << k))
                k++;
            return k;
        end
    endfunction

    task automatic predict_particles(input logic [CELL_W-1:0] cell_id,
                                     input logic [Q_W-1:0] qlo, input logic [Q_W-1:0] qhi);
        logic [63:0] sum;
        logic [63:0] x0;
        logic [63:0] pos;
        logic [63:0] start [2];
        logic [63:0] len [2];
        logic [63:0] chg [2];
        int          lvl [2];
        int          r;
        int          m;
        int          pieces;
        begin
            sum = {32'd0, qlo} + {32'd0, qhi};
            if (sum != 64'd0)
            begin
                x0       = ({32'd0, qhi} << 16) / sum;
                start[0] = 64'd0;
                len[0]   = x0;
                chg[0]   = {32'd0, qlo};
                start[1] = x0;
                len[1]   = 64'd65536 - x0;
                chg[1]   = {32'd0, qhi};
                for (r = 0; r < 2; r++)
                begin
                    lvl[r] = split_level(chg[r], cfg_target);
                    if (lvl[r] == MAX_LVL)
                        n_saturated++;
                end
                // high region goes out first
                for (r = 1; r >= 0; r--)
                begin
                    pieces = 1 << lvl[r];
                    for (m = 0; m < pieces; m++)
                    begin
                        pos = start[r] + ((64'(2 * m + 1) * len[r]) >> (lvl[r] + 1));
                        push_particle(cell_id, pos[POS_W-1:0], Q_W'(chg[r] >> lvl[r]),
                                      (r == 0 && m == pieces - 1));
                    end
                end
            end
        end
    endtask

    task automatic send_cell(input logic [CELL_W-1:0] cell_id, input logic [Q_W-1:0] qlo,
                             input logic [Q_W-1:0] qhi, input bit predict);
        begin
            while (!no_idle && $urandom_range(99) < 14)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {qhi, qlo, cell_id};
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            n_cells++;
            if (qlo == '0 && qhi == '0)
                n_zero++;
            if (predict)
                predict_particles(cell_id, qlo, qhi);
            @(negedge clk);
        end
    endtask

    // called at a falling edge; lets the block go quiet before going on
    task automatic drain_outputs();
        begin
            s_tvalid <= 1'b0;
            while (exp_particles.size() != 0)
                @(negedge clk);
            repeat (HOLD_OFF) @(negedge clk);
        end
    endtask

    task automatic reg_write_check(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] val);
        logic [DATA_W-1:0] readback;
        begin
            @(negedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= addr;
            pwdata  <= val;
            @(negedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            if (addr == ADDR_TARGET)
            begin
                cfg_target = val;
                readback   = val;
            end
            else
            begin
                cfg_species = val[SPEC_W-1:0];
                readback    = {{(DATA_W-SPEC_W){1'b0}}, val[SPEC_W-1:0]};
            end
            @(negedge clk);
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(negedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            if (prdata !== readback)
                report_mismatch("register readback",
                                $sformatf("addr %0d expected %h actual %h", addr, readback, prdata));
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    function automatic logic [Q_W-1:0] rand_charge(input logic [Q_W-1:0] t);
        logic [63:0] base;
        begin
            base = {32'd0, t} << $urandom_range(0, 6);
            case ($urandom_range(9))
                0:       base = 64'd0;
                1, 6:    base = {32'd0, $urandom};
                2:       base = 64'($urandom_range(0, 255));
                3:       base = base - 64'd1;
                4:       base = base + 64'd1;
                5:       base = (base * 64'($urandom_range(1, 99))) / 64'd100;
                default: base = base;
            endcase
            if (base > 64'hFFFF_FFFF)
                base = 64'hFFFF_FFFF;
            return base[Q_W-1:0];
        end
    endfunction

    always @(negedge clk)
    begin
        m_tready <= no_idle || ($urandom_range(99) >= 14);
    end

    // output checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            n_particles++;
            if (exp_particles.size() == 0)
            begin
                report_mismatch("unexpected particle",
                                $sformatf("cell %h pos %h weight %h", m_tdata[15:0],
                                          m_tdata[32:16], m_tdata[64:33]));
            end
            else
            begin
                exp_p = exp_particles.pop_front();
                if (m_tdata[15:0] !== exp_p.cell_id || m_tuser !== exp_p.species ||
                    m_tdata[32:16] !== exp_p.pos || m_tdata[64:33] !== exp_p.weight ||
                    m_tlast !== exp_p.last)
                begin
                    report_mismatch("particle",
                        {$sformatf("expected cell %h sp %h pos %h w %h last %b, ",
                                   exp_p.cell_id, exp_p.species, exp_p.pos, exp_p.weight,
                                   exp_p.last),
                         $sformatf("actual cell %h sp %h pos %h w %h last %b",
                                   m_tdata[15:0], m_tuser, m_tdata[32:16], m_tdata[64:33],
                                   m_tlast)});
                end
            end
        end
    end

    // watchdog on cycles with no transaction anywhere
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [Q_W-1:0] lo;
        logic [Q_W-1:0] hi;
        int             i;
        int             ph;

        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        no_idle     = 1'b0;
        errors      = 0;
        n_cells     = 0;
        n_zero      = 0;
        n_particles = 0;
        n_saturated = 0;
        n_settings  = 1;
        idle_cycles = 0;
        cfg_target  = TARGET_RESET;
        cfg_species = '0;

        // rows under the reset target of 1.0 and species 0
        dir_rows = '{
            '{16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 2'd0, 17'd0, 32'd0, 17'd0, 32'd0},
            '{16'hFFFF, 32'h0001_0000, 32'h0000_0000, 1'b1, 2'd2,
              17'd32768, 32'd0, 17'd0, 32'h0001_0000},
            '{16'h0001, 32'h0000_0000, 32'h0001_0000, 1'b1, 2'd2,
              17'd65536, 32'h0001_0000, 17'd32768, 32'd0},
            '{16'h0002, 32'h0001_0000, 32'h0001_0000, 1'b1, 2'd2,
              17'd49152, 32'h0001_0000, 17'd16384, 32'h0001_0000},
            '{16'h0003, 32'h0000_0001, 32'h0000_0001, 1'b1, 2'd2,
              17'd49152, 32'd1, 17'd16384, 32'd1},
            '{16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 2'd0, 17'd0, 32'd0, 17'd0, 32'd0},
            '{16'hAAAA, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 2'd0, 17'd0, 32'd0, 17'd0, 32'd0},
            '{16'h5555, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 2'd0, 17'd0, 32'd0, 17'd0, 32'd0},
            '{16'h0004, 32'h0001_0001, 32'h0001_0000, 1'b0, 2'd0, 17'd0, 32'd0, 17'd0, 32'd0},
            '{16'h0005, 32'h0002_0000, 32'h0002_0001, 1'b0, 2'd0, 17'd0, 32'd0, 17'd0, 32'd0},
            '{16'h0006, 32'h0004_0000, 32'h0008_0000, 1'b0, 2'd0, 17'd0, 32'd0, 17'd0, 32'd0},
            '{16'h0007, 32'h001F_0000, 32'h0010_0000, 1'b0, 2'd0, 17'd0, 32'd0, 17'd0, 32'd0},
            '{16'h0008, 32'h0020_0000, 32'h0020_0001, 1'b0, 2'd0, 17'd0, 32'd0, 17'd0, 32'd0},
            '{16'h0009, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 2'd0, 17'd0, 32'd0, 17'd0, 32'd0},
            '{16'h000A, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 2'd0, 17'd0, 32'd0, 17'd0, 32'd0},
            '{16'h000B, 32'h0000_8000, 32'h0000_0000, 1'b0, 2'd0, 17'd0, 32'd0, 17'd0, 32'd0},
            '{16'h000C, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 2'd0, 17'd0, 32'd0, 17'd0, 32'd0},
            '{16'h8000, 32'h0000_0003, 32'h0000_0000, 1'b0, 2'd0, 17'd0, 32'd0, 17'd0, 32'd0}
        };

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < NUM_ROWS; i++)
        begin
            send_cell(dir_rows[i].cell_id, dir_rows[i].qlo, dir_rows[i].qhi, !dir_rows[i].typed);
            if (dir_rows[i].typed && dir_rows[i].n >= 2'd1)
                push_particle(dir_rows[i].cell_id, dir_rows[i].pos0, dir_rows[i].w0,
                              dir_rows[i].n == 2'd1);
            if (dir_rows[i].typed && dir_rows[i].n == 2'd2)
                push_particle(dir_rows[i].cell_id, dir_rows[i].pos1, dir_rows[i].w1, 1'b1);
        end

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain_outputs();
            case (ph)
                0:
                begin
                    reg_write_check(ADDR_TARGET, 32'h0000_0001);
                    reg_write_check(ADDR_SPECIES, 32'h0000_000F);
                end
                1:
                begin
                    reg_write_check(ADDR_TARGET, 32'hFFFF_FFFF);
                    reg_write_check(ADDR_SPECIES, 32'h0000_0000);
                end
                2:
                begin
                    // zero target forces the deepest split on any nonzero charge
                    reg_write_check(ADDR_TARGET, 32'h0000_0000);
                    reg_write_check(ADDR_SPECIES, 32'h0000_000A);
                end
                3:
                begin
                    reg_write_check(ADDR_TARGET, 32'h0003_0000);
                    reg_write_check(ADDR_SPECIES, 32'h0000_0005);
                end
                4:
                begin
                    reg_write_check(ADDR_TARGET, $urandom_range(1, 32'h0040_0000));
                    reg_write_check(ADDR_SPECIES, $urandom);
                end
                default:
                begin
                    reg_write_check(ADDR_TARGET, $urandom | 32'h1);
                    reg_write_check(ADDR_SPECIES, $urandom);
                end
            endcase
            n_settings++;
            no_idle = (ph == 3);
            for (i = 0; i < PHASE_CELLS; i++)
            begin
                if ($urandom_range(99) < 3)
                    drain_outputs();
                if ($urandom_range(99) < 5)
                begin
                    lo = '0;
                    hi = '0;
                end
                else
                begin
                    lo = rand_charge(cfg_target);
                    hi = rand_charge(cfg_target);
                end
                send_cell(CELL_W'($urandom), lo, hi, 1'b1);
            end
        end

        no_idle = 1'b0;
        drain_outputs();
        if (exp_particles.size() != 0)
            report_mismatch("missing particles", $sformatf("%0d left", exp_particles.size()));

        $display("covered %0d cells (%0d with zero charge, %0d saturated regions)",
                 n_cells, n_zero, n_saturated);
        $display("checked %0d particles over %0d register settings", n_particles, n_settings);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
hdl/ccps_pkg.sv
hdl/ccps_apb_regs.sv
hdl/ccps_div_unit.sv
hdl/ccps_level_unit.sv
hdl/cell_charge_particle_splitter_top.sv
sim/testbench.sv
